// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/a52_kg_pkg.sv =====
// ----------------------------------------------------------------------------
// A5/2 keystream generator package
// Register widths, tap masks, request codes and the LFSR step functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package a52_kg_pkg;

  localparam int KEY_BITS   = 64;
  localparam int FRAME_BITS = 22;
  localparam int CNT_W      = $clog2(KEY_BITS);
  localparam int FRM_W      = $clog2(FRAME_BITS);

  typedef logic [18:0] r1_t;
  typedef logic [21:0] r2_t;
  typedef logic [22:0] r3_t;
  typedef logic [16:0] r4_t;
  typedef logic [2:0]  req_t;

  localparam req_t REQ_KEY_SETUP  = 3'd0;
  localparam req_t REQ_KEYSTREAM  = 3'd1;
  localparam req_t REQ_STATE_INIT = 3'd2;
  localparam req_t REQ_R4_VALUE   = 3'd3;
  localparam req_t REQ_R4_LOAD    = 3'd4;

  localparam logic CFG_SESSION_KEY  = 1'b0;
  localparam logic CFG_FRAME_NUMBER = 1'b1;

  localparam r1_t TAP1 = 19'h72000;
  localparam r2_t TAP2 = 22'h300000;
  localparam r3_t TAP3 = 23'h700080;
  localparam r4_t TAP4 = 17'h10800;

  localparam r1_t FORCE1 = 19'h08000;
  localparam r2_t FORCE2 = 22'h010000;
  localparam r3_t FORCE3 = 23'h040000;
  localparam r4_t FORCE4 = 17'h00400;

  localparam int CK1_BIT = 10;
  localparam int CK2_BIT = 3;
  localparam int CK3_BIT = 7;

  function automatic logic maj3(logic a, logic b, logic c);
    return (a & b) | (a & c) | (b & c);
  endfunction

  function automatic r1_t step1(r1_t s);
    return {s[17:0], ^(s & TAP1)};
  endfunction

  function automatic r2_t step2(r2_t s);
    return {s[20:0], ^(s & TAP2)};
  endfunction

  function automatic r3_t step3(r3_t s);
    return {s[21:0], ^(s & TAP3)};
  endfunction

  function automatic r4_t step4(r4_t s);
    return {s[15:0], ^(s & TAP4)};
  endfunction

  // Output bit of each large register: top bit XOR majority, one tap inverted.
  function automatic logic obit1(r1_t s);
    return s[18] ^ maj3(s[15], s[12], ~s[14]);
  endfunction

  function automatic logic obit2(r2_t s);
    return s[21] ^ maj3(s[13], s[9], ~s[16]);
  endfunction

  function automatic logic obit3(r3_t s);
    return s[22] ^ maj3(s[18], s[16], ~s[13]);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/a5_2_keystream_generator_top.sv =====
// ----------------------------------------------------------------------------
// A5/2 keystream generator
// Four LFSRs with majority clocking; key setup, state setup, keystream and R4 services.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// One round unit steps all four registers (or a scratch copy of R4) once per
// cycle under a small sequencer. Keystream, R4 load and unused requests finish
// in the accept cycle, so one beat per cycle while results are taken. The R4
// value request runs 22 frame rounds, setup from states 22 frame rounds plus
// priming and key setup 64 key rounds, 22 frame rounds and priming. The block
// takes no new beat while a request runs or while its result is still waiting
// to be taken.
`include "assert_macros.svh"

module a5_2_keystream_generator_top (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_we,
  input  wire                     cfg_index,
  input  wire [63:0]              cfg_data,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  a52_kg_pkg::req_t        req_type,
  input  a52_kg_pkg::r1_t         r1_in,
  input  a52_kg_pkg::r2_t         r2_in,
  input  a52_kg_pkg::r3_t         r3_in,
  input  a52_kg_pkg::r4_t         r4_in,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic                    key_bit,
  output a52_kg_pkg::r1_t         r1_out,
  output a52_kg_pkg::r2_t         r2_out,
  output a52_kg_pkg::r3_t         r3_out,
  output a52_kg_pkg::r4_t         r4_out,
  output logic                    error
);
  import a52_kg_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_KEY   = 2'd1;
  localparam logic [1:0] ST_FRAME = 2'd2;
  localparam logic [1:0] ST_PRIME = 2'd3;

  localparam logic [CNT_W-1:0] KEY_LAST   = CNT_W'(KEY_BITS - 1);
  localparam logic [CNT_W-1:0] FRAME_LAST = CNT_W'(FRAME_BITS - 1);

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;
  req_t             mode;
  logic [63:0]      session_key;
  logic [21:0]      frame_number;

  r1_t  reg_one;
  r2_t  reg_two;
  r3_t  reg_three;
  r4_t  clock_reg;
  r4_t  scratch_r4;
  logic out_bit_one, out_bit_two, out_bit_three;

  logic in_accept;
  logic mix_bit;
  r4_t  r4_src;
  r1_t  rnd1;
  r2_t  rnd2;
  r3_t  rnd3;
  r4_t  rnd4;
  logic maj_ck, c1, c2, c3;
  logic nb1, nb2, nb3;

  assign in_ready  = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_accept = in_valid && in_ready;

  // Shared round: regular step of every register, then the mix bit into bit 0.
  always_comb begin
    mix_bit = (state == ST_KEY) ? session_key[cnt] : frame_number[cnt[FRM_W-1:0]];
    r4_src  = (mode == REQ_R4_VALUE) ? scratch_r4 : clock_reg;
    rnd1    = step1(reg_one)   ^ {18'b0, mix_bit};
    rnd2    = step2(reg_two)   ^ {21'b0, mix_bit};
    rnd3    = step3(reg_three) ^ {22'b0, mix_bit};
    rnd4    = step4(r4_src)    ^ {16'b0, mix_bit};
  end

  // Majority clocking for a keystream beat.
  always_comb begin
    maj_ck = maj3(clock_reg[CK1_BIT], clock_reg[CK2_BIT], clock_reg[CK3_BIT]);
    c1     = clock_reg[CK1_BIT] == maj_ck;
    c2     = clock_reg[CK2_BIT] == maj_ck;
    c3     = clock_reg[CK3_BIT] == maj_ck;
    nb1    = c1 ? obit1(reg_one)   : out_bit_one;
    nb2    = c2 ? obit2(reg_two)   : out_bit_two;
    nb3    = c3 ? obit3(reg_three) : out_bit_three;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      mode          <= REQ_KEY_SETUP;
      out_valid     <= 1'b0;
      session_key   <= '0;
      frame_number  <= '0;
      reg_one       <= '0;
      reg_two       <= '0;
      reg_three     <= '0;
      clock_reg     <= '0;
      out_bit_one   <= 1'b0;
      out_bit_two   <= 1'b0;
      out_bit_three <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SESSION_KEY:  session_key  <= cfg_data;
          CFG_FRAME_NUMBER: frame_number <= cfg_data[21:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            mode    <= req_type;
            cnt     <= '0;
            key_bit <= 1'b0;
            r1_out  <= '0;
            r2_out  <= '0;
            r3_out  <= '0;
            r4_out  <= '0;
            error   <= 1'b0;
            case (req_type)
              REQ_KEY_SETUP: begin
                reg_one   <= '0;
                reg_two   <= '0;
                reg_three <= '0;
                clock_reg <= '0;
                state     <= ST_KEY;
              end
              REQ_KEYSTREAM: begin
                clock_reg <= step4(clock_reg);
                if (c1) reg_one   <= step1(reg_one);
                if (c2) reg_two   <= step2(reg_two);
                if (c3) reg_three <= step3(reg_three);
                out_bit_one   <= nb1;
                out_bit_two   <= nb2;
                out_bit_three <= nb3;
                key_bit       <= nb1 ^ nb2 ^ nb3;
                out_valid     <= 1'b1;
              end
              REQ_STATE_INIT: begin
                reg_one   <= r1_in;
                reg_two   <= r2_in;
                reg_three <= r3_in;
                clock_reg <= r4_in;
                state     <= ST_FRAME;
              end
              REQ_R4_VALUE: begin
                scratch_r4 <= r4_in;
                state      <= ST_FRAME;
              end
              REQ_R4_LOAD: begin
                if (r4_in[CK1_BIT]) clock_reg <= r4_in;
                else error <= 1'b1;
                out_valid <= 1'b1;
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        ST_KEY: begin
          reg_one   <= rnd1;
          reg_two   <= rnd2;
          reg_three <= rnd3;
          clock_reg <= rnd4;
          cnt       <= cnt + 1'b1;
          if (cnt == KEY_LAST) begin
            cnt   <= '0;
            state <= ST_FRAME;
          end
        end
        ST_FRAME: begin
          cnt <= cnt + 1'b1;
          if (mode == REQ_R4_VALUE) begin
            scratch_r4 <= rnd4;
            if (cnt == FRAME_LAST) begin
              r4_out    <= rnd4 | FORCE4;
              out_valid <= 1'b1;
              state     <= ST_IDLE;
            end
          end else begin
            // Force the fixed bits on the last frame round.
            if (cnt == FRAME_LAST) begin
              reg_one   <= rnd1 | FORCE1;
              reg_two   <= rnd2 | FORCE2;
              reg_three <= rnd3 | FORCE3;
              clock_reg <= rnd4 | FORCE4;
              state     <= ST_PRIME;
            end else begin
              reg_one   <= rnd1;
              reg_two   <= rnd2;
              reg_three <= rnd3;
              clock_reg <= rnd4;
            end
          end
        end
        ST_PRIME: begin
          if (mode == REQ_STATE_INIT) begin
            r1_out <= reg_one;
            r2_out <= reg_two;
            r3_out <= reg_three;
            r4_out <= clock_reg;
          end
          out_bit_one   <= obit1(reg_one);
          out_bit_two   <= obit2(reg_two);
          out_bit_three <= obit3(reg_three);
          reg_one       <= step1(reg_one);
          reg_two       <= step2(reg_two);
          reg_three     <= step3(reg_three);
          out_valid     <= 1'b1;
          state         <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A running request never has a result pending.
  `ASSERT_IMPLY(a_busy_no_result, clk, rst, state != ST_IDLE, !out_valid)
  // Setup leaves bit 10 of the clocking register set.
  `ASSERT_NEXT(a_prime_r4_forced, clk, rst, state == ST_PRIME, clock_reg[CK1_BIT])
  // Key rounds run only for a key setup request.
  `ASSERT_IMPLY(a_key_mode, clk, rst, state == ST_KEY, mode == REQ_KEY_SETUP)

endmodule

`default_nettype wire
